// ===== hw/rtl/region_change_sensitivity_unit_assert.svh =====
// Assertion macros shared by the region change sensitivity RTL
`ifndef REGION_CHANGE_SENSITIVITY_UNIT_ASSERT_SVH
`define REGION_CHANGE_SENSITIVITY_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcs assertion failed");

// Consequent must hold in the cycle after the antecedent
`define RCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcs assertion failed");

`endif

// ===== hw/rtl/rcs_pkg.sv =====
// Shared types and constants of the region change sensitivity block
`default_nettype none

package rcs_pkg;

    localparam int FRAME_PIXELS = 2097152;
    localparam int REGIONS      = 8;
    localparam int NREG         = (REGIONS > 8) ? 8 : REGIONS;
    localparam int IDX_W        = $clog2(FRAME_PIXELS);
    localparam int PIX_W        = 8;
    localparam int SUM_W        = 29;
    localparam int REG_W        = 3;
    localparam int SENS_W       = 7;
    localparam int QUO_W        = 7;
    localparam int DIV_W        = SUM_W + QUO_W;

    localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
    localparam logic [SENS_W-1:0] PERCENT = SENS_W'(100);

    localparam logic KIND_DETECT = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef enum logic [0:0] {
        CFG_MANUAL_UPDATE = 1'b0,
        CFG_REGION_ENABLE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
        logic [7:0]       region_mask;
        logic             end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [REG_W-1:0]  region;
        logic              valid_res;
        logic [SENS_W-1:0] sensitivity;
        logic [SUM_W-1:0]  total_change;
        logic [SUM_W-1:0]  region_change;
        logic              last;
    } t_out_item;

    // Frame sums handed to the report engine at the end of a detect frame
    typedef struct packed {
        logic [SUM_W-1:0]            total;
        logic [NREG-1:0][SUM_W-1:0]  sums;
    } t_rpt_snap;

endpackage

`default_nettype wire

// ===== hw/rtl/region_change_sensitivity_unit.sv =====
// Report: an end-of-frame detect pixel passes the input pipeline register, then each region in turn goes through
// a multiply step, the shared 7-step divider and the output register; each region waits until the last is taken.
// Throughput: one pixel per cycle through the reference memory read-modify-write;
// an end-of-frame detect pixel waits while the previous frame's report is still running.
// Reset: control, index, sums and registers cleared, next detect frame only loads the reference;
// the reference memory is not cleared.
`default_nettype none

module region_change_sensitivity_unit
    import rcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in_item   i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_data,
    input  wire logic       i_cfg_we,
    input  wire t_cfg_idx   i_cfg_idx,
    input  wire logic [7:0] i_cfg_wdata
);

    `include "region_change_sensitivity_unit_assert.svh"

    typedef struct packed {
        logic             store;
        logic             eof;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] pix;
        logic [NREG-1:0]  mask;
    } t_stage;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    logic r_manual_update;
    logic [7:0] r_region_enable;
    logic r_first_frame;
    logic [IDX_W-1:0] r_idx;
    logic r_s1_vld;
    t_stage r_s1;
    logic r_fwd_hit;
    logic [PIX_W-1:0] r_fwd_pix;
    logic [PIX_W-1:0] r_ref_rd;
    logic [SUM_W-1:0] r_total;
    logic [NREG-1:0][SUM_W-1:0] r_sums;
    logic [PIX_W-1:0] r_ref_mem [FRAME_PIXELS];

    logic w_acc;
    logic w_in_eof_det;
    logic w_s1_eof_det;
    logic w_rpt_busy;
    logic w_wr_en;
    logic [PIX_W-1:0] w_ref;
    logic [PIX_W-1:0] w_diff;
    logic [SUM_W-1:0] w_tot_add;
    logic [NREG-1:0][SUM_W-1:0] w_sums_add;
    logic w_sums_ok;
    logic [IDX_W-1:0] n_idx;
    t_stage n_s1;
    t_rpt_snap w_snap;

    // A second frame end may not enter while the report engine is engaged
    assign w_in_eof_det = i_data.end_of_frame && (i_data.kind == KIND_DETECT) && !r_first_frame;
    assign w_s1_eof_det = r_s1_vld && r_s1.eof && !r_s1.store;
    assign o_ready      = !(w_in_eof_det && (w_rpt_busy || w_s1_eof_det));
    assign w_acc        = i_valid && o_ready;

    always_comb begin
        n_s1.store = (i_data.kind == KIND_LOAD) || r_first_frame;
        n_s1.eof   = i_data.end_of_frame;
        n_s1.idx   = r_idx;
        n_s1.pix   = i_data.pixel;
        n_s1.mask  = i_data.region_mask[NREG-1:0];
        if (i_data.end_of_frame || (r_idx == IDX_W'(FRAME_PIXELS - 1))) begin
            n_idx = '0;
        end else begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        w_wr_en = r_s1_vld && (r_s1.store || !r_manual_update);
        w_ref   = r_fwd_hit ? r_fwd_pix : r_ref_rd;
        w_diff  = (r_s1.pix >= w_ref) ? (r_s1.pix - w_ref) : (w_ref - r_s1.pix);
        w_tot_add = sat_add(r_total, w_diff);
        w_sums_ok = 1'b1;
        for (int k = 0; k < NREG; k++) begin
            w_sums_add[k] = r_s1.mask[k] ? sat_add(r_sums[k], w_diff) : r_sums[k];
            w_sums_ok     = w_sums_ok && (r_sums[k] <= r_total);
        end
        w_snap.total = w_tot_add;
        w_snap.sums  = w_sums_add;
    end

    // Reference memory: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ref_rd <= r_ref_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ref_mem[r_s1.idx] <= r_s1.pix;
        end
    end

    // Forward the write-back when the next read hits the same entry
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1      <= n_s1;
            r_fwd_hit <= w_wr_en && (r_s1.idx == r_idx);
            r_fwd_pix <= r_s1.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual_update <= 1'b0;
            r_region_enable <= '0;
            r_first_frame   <= 1'b1;
            r_idx           <= '0;
            r_s1_vld        <= 1'b0;
            r_total         <= '0;
            r_sums          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MANUAL_UPDATE: r_manual_update <= i_cfg_wdata[0];
                    CFG_REGION_ENABLE: r_region_enable <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_s1_vld <= w_acc;
            if (w_acc) begin
                r_idx <= n_idx;
                if (i_data.kind == KIND_DETECT && i_data.end_of_frame) begin
                    r_first_frame <= 1'b0;
                end
            end
            if (r_s1_vld) begin
                if (r_s1.eof) begin
                    r_total <= '0;
                    r_sums  <= '0;
                end else if (!r_s1.store) begin
                    r_total <= w_tot_add;
                    r_sums  <= w_sums_add;
                end
            end
        end
    end

    rcs_report u_report (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_s1_eof_det),
        .i_snap          (w_snap),
        .i_region_enable (r_region_enable),
        .o_busy          (w_rpt_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_data          (o_data)
    );

    `RCS_ASSERT_NOW(a_eof_not_busy, w_s1_eof_det, !w_rpt_busy)
    `RCS_ASSERT_NOW(a_sums_order, 1'b1, w_sums_ok)
    `RCS_ASSERT_NEXT(a_eof_clears, r_s1_vld && r_s1.eof, r_total == '0 && r_sums == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/rcs_report.sv =====
// Frame-end report engine: per-region share division and result output register
`default_nettype none

module rcs_report
    import rcs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_rpt_snap i_snap,
    input  wire logic [7:0] i_region_enable,
    output logic           o_busy,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    `include "region_change_sensitivity_unit_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                     r_state;
    logic [REG_W-1:0]           r_reg;
    logic [2:0]                 r_cnt;
    logic [SUM_W-1:0]           r_total;
    logic [NREG-1:0][SUM_W-1:0] r_sums;
    logic [DIV_W-1:0]           r_rem;
    logic [DIV_W-1:0]           r_div;
    logic [QUO_W-1:0]           r_q;
    t_out_item                  r_out;

    logic [SUM_W-1:0]  w_sum;
    logic [DIV_W-1:0]  w_prod;
    logic              w_ge;
    logic [QUO_W-1:0]  w_q_nxt;
    logic              w_en;
    logic              w_zero;
    logic [SENS_W-1:0] w_sens;
    t_out_item         n_out;

    always_comb begin
        w_sum   = r_sums[r_reg];
        w_prod  = DIV_W'(w_sum) * DIV_W'(PERCENT);
        w_ge    = (r_rem >= r_div);
        w_q_nxt = {r_q[QUO_W-2:0], w_ge};
        w_en    = i_region_enable[r_reg];
        w_zero  = (r_total == '0) || (w_sum == '0);
        if (w_zero) begin
            w_sens = PERCENT;
        end else if (w_q_nxt >= PERCENT) begin
            w_sens = '0;
        end else begin
            w_sens = PERCENT - w_q_nxt;
        end
        n_out.region        = r_reg;
        n_out.valid_res     = w_en;
        n_out.sensitivity   = w_en ? w_sens : '0;
        n_out.total_change  = w_en ? r_total : '0;
        n_out.region_change = w_en ? w_sum : '0;
        n_out.last          = (r_reg == REG_W'(NREG - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_reg   <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_reg   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt   <= 3'(QUO_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt - 3'd1;
                    end
                end
                S_OUT: begin
                    // advance to the next region, or return to idle after the last, once the transaction completes
                    if (i_ready) begin
                        if (r_reg == REG_W'(NREG - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_reg   <= r_reg + REG_W'(1);
                            r_state <= S_MUL;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_total <= i_snap.total;
            r_sums  <= i_snap.sums;
        end
        if (r_state == S_MUL) begin
            r_rem <= w_prod;
            r_div <= DIV_W'(r_total) << (QUO_W - 1);
            r_q   <= '0;
        end
        if (r_state == S_DIV) begin
            if (w_ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_q   <= w_q_nxt;
            if (r_cnt == '0) begin
                r_out <= n_out;
            end
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    `RCS_ASSERT_NOW(a_start_idle, i_start, r_state == S_IDLE)
    `RCS_ASSERT_NOW(a_sens_range, o_valid, o_data.sensitivity <= PERCENT)
    `RCS_ASSERT_NOW(a_region_le_total, o_valid,
        o_data.region_change <= o_data.total_change)
    `RCS_ASSERT_NEXT(a_hold_out, o_valid && !i_ready, o_valid && $stable(o_data))

endmodule

`default_nettype wire
